// File: rtl/igfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package igfc_pkg;

    localparam int FRAME_DEPTH = 256;
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
    localparam int LEN_W       = 9;
    localparam int PAY_FIRST   = 5;
    localparam int PAY_LAST    = 15;
    localparam int PAY_LEN     = PAY_LAST - PAY_FIRST + 1;
    localparam int PAY_IDX_W   = $clog2(PAY_LEN);
    localparam int MIN_FRAME   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] IDLE_TICKS_RESET   = 8'd5;
    localparam logic [7:0] START_MARKER_RESET = 8'hAA;
    localparam logic [7:0] END_MARKER_RESET   = 8'h55;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_TICKS   = 2'd0,
        CFG_START_MARKER = 2'd1,
        CFG_END_MARKER   = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_BAD_START = 3'd3,
        ST_BAD_END   = 3'd4,
        ST_BAD_SUM   = 3'd5
    } status_t;

    typedef logic [PAY_LEN-1:0][7:0] pay_t;

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   length;
        pay_t               pay;
    } close_rec_t;

endpackage

`default_nettype wire

// File: rtl/igfc_item_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface igfc_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/igfc_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface igfc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [8:0]  frame_length;
    logic [31:0] timestamp;
    logic [15:0] phase_one;
    logic [15:0] phase_two;
    logic [15:0] phase_three;
    logic [7:0]  result_code;

    modport source (
        output valid, output status, output frame_length, output timestamp,
        output phase_one, output phase_two, output phase_three, output result_code,
        input ready
    );
    modport sink (
        input valid, input status, input frame_length, input timestamp,
        input phase_one, input phase_two, input phase_three, input result_code,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/igfc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module igfc_front
    import igfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    igfc_item_if.sink                  item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  q_full,
    output logic                       q_push,
    output close_rec_t                 q_rec
);

    logic [7:0]       idle_ticks_reg;
    logic [7:0]       start_marker_reg;
    logic [7:0]       end_marker_reg;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       idle_count_reg, idle_count_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       last_reg, last_next;
    logic             ovf_reg, ovf_next;
    pay_t             pend_reg, pend_next;

    logic                   accept;
    logic [7:0]             idle_inc;
    logic [PAY_IDX_W-1:0]   pay_idx;
    status_t                status;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign idle_inc   = (idle_count_reg == 8'hFF) ? idle_count_reg : idle_count_reg + 8'd1;
    assign pay_idx    = PAY_IDX_W'(byte_count_reg - CNT_W'(PAY_FIRST));

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg   <= IDLE_TICKS_RESET;
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDLE_TICKS:   idle_ticks_reg   <= cfg_data;
                CFG_START_MARKER: start_marker_reg <= cfg_data;
                CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // frame check, first failing test wins
    always_comb
    begin
        priority if (ovf_reg)
            status = ST_OVERFLOW;
        else if (byte_count_reg < CNT_W'(MIN_FRAME))
            status = ST_SHORT;
        else if (first_reg != start_marker_reg)
            status = ST_BAD_START;
        else if (last_reg != end_marker_reg)
            status = ST_BAD_END;
        else if ((xor_reg ^ last_reg) != 8'd0)
            status = ST_BAD_SUM;
        else
            status = ST_OK;
    end

    assign q_rec.status = status;
    assign q_rec.length = LEN_W'(byte_count_reg);
    assign q_rec.pay    = pend_reg;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        idle_count_next = idle_count_reg;
        xor_next        = xor_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        ovf_next        = ovf_reg;
        pend_next       = pend_reg;
        q_push          = 1'b0;
        if (accept)
        begin
            if (item.opcode == OP_BYTE)
            begin
                idle_count_next = 8'd0;
                if (byte_count_reg < CNT_W'(FRAME_DEPTH))
                begin
                    if (byte_count_reg == '0)
                        first_next = item.rx_byte;
                    if (byte_count_reg >= CNT_W'(PAY_FIRST)
                        && byte_count_reg <= CNT_W'(PAY_LAST))
                        pend_next[pay_idx] = item.rx_byte;
                    last_next       = item.rx_byte;
                    xor_next        = xor_reg ^ item.rx_byte;
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (byte_count_reg != '0)
            begin
                if (idle_inc >= idle_ticks_reg)
                begin
                    q_push          = 1'b1;
                    byte_count_next = '0;
                    idle_count_next = 8'd0;
                    xor_next        = 8'd0;
                    first_next      = 8'd0;
                    last_next       = 8'd0;
                    ovf_next        = 1'b0;
                    pend_next       = '0;
                end
                else
                begin
                    idle_count_next = idle_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            idle_count_reg <= 8'd0;
            xor_reg        <= 8'd0;
            first_reg      <= 8'd0;
            last_reg       <= 8'd0;
            ovf_reg        <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            idle_count_reg <= idle_count_next;
            xor_reg        <= xor_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            ovf_reg        <= ovf_next;
            pend_reg       <= pend_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> accept && item.opcode == OP_TICK && byte_count_reg != '0)
        else $error("close without an accepted tick on an open frame");
    a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> byte_count_reg == '0 && !ovf_reg)
        else $error("frame state not cleared after close");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(FRAME_DEPTH))
        else $error("byte count beyond frame depth");
`endif

endmodule

`default_nettype wire

// File: rtl/igfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module igfc_queue
    import igfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire close_rec_t push_rec,
    input  wire logic       pop,
    output logic            full,
    output logic            not_empty,
    output close_rec_t      pop_rec
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    close_rec_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign full      = fill_reg == FILL_W'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign pop_rec   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + FILL_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - FILL_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/igfc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module igfc_back
    import igfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_not_empty,
    input  wire close_rec_t q_rec,
    output logic            q_pop,
    igfc_result_if.source   result
);

    pay_t             pub_reg, pub_next;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [LEN_W-1:0] out_len_reg;
    pay_t             out_pay_reg;

    assign q_pop    = q_not_empty && (!out_valid_reg || result.ready);
    // a good frame replaces the published values, a bad one repeats them
    assign pub_next = (q_rec.status == ST_OK) ? q_rec.pay : pub_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                pub_reg       <= pub_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_status_reg <= q_rec.status;
            out_len_reg    <= q_rec.length;
            out_pay_reg    <= pub_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.frame_length = out_len_reg;
    assign result.timestamp    = {out_pay_reg[3], out_pay_reg[2], out_pay_reg[1], out_pay_reg[0]};
    assign result.phase_one    = {out_pay_reg[5], out_pay_reg[4]};
    assign result.phase_two    = {out_pay_reg[7], out_pay_reg[6]};
    assign result.phase_three  = {out_pay_reg[9], out_pay_reg[8]};
    assign result.result_code  = out_pay_reg[10];

`ifndef NO_ASSERTIONS
    a_published_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_rec.status == ST_OK) |=> $stable(pub_reg))
        else $error("published values changed without a good frame");
    a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_pay_reg))
        else $error("pending result word lost");
`endif

endmodule

`default_nettype wire

// File: rtl/idle_gap_frame_checker.sv
// Idle-gap serial frame checker. Each input word is a received byte or one
// timer tick; a frame closes when idle_ticks ticks (zero acts as one) pass
// without a byte, and each closed frame gives one result word with a status
// (overflow, too short, bad start, bad end, bad checksum, in that priority)
// and the timestamp, phase and result fields of the last good frame. Bytes
// past 256 are dropped and flag overflow. One input word is taken every
// cycle; the front end keeps the running checksum and counters in registers
// and hands closed frames through a two-entry queue to the result stage;
// input stalls only when that queue and the output register are both full.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module idle_gap_frame_checker
    import igfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    igfc_item_if.sink                  item,
    igfc_result_if.source              result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_not_empty;
    close_rec_t push_rec;
    close_rec_t pop_rec;

    igfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (push_rec)
    );

    igfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (push_rec),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_rec   (pop_rec)
    );

    igfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rec       (pop_rec),
        .q_pop       (q_pop),
        .result      (result)
    );

endmodule

`default_nettype wire

// File: dv/idle_gap_frame_checker_tb.sv
`timescale 1ns / 1ps

module idle_gap_frame_checker_tb;
    import igfc_pkg::*;

    localparam int ITEMS_TARGET = 1750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 10;

    typedef enum {CLEAN, BAD_HEAD, BAD_TAIL, BAD_SUM} frame_flaw_t;

    typedef struct packed {
        status_t     status;
        logic [8:0]  frame_length;
        logic [31:0] timestamp;
        logic [15:0] phase_one;
        logic [15:0] phase_two;
        logic [15:0] phase_three;
        logic [7:0]  result_code;
    } frame_report_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    logic [7:0] cfg_data;

    igfc_item_if   item_bus ();
    igfc_result_if result_bus ();

    idle_gap_frame_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    logic [7:0] gap_ticks;
    logic [7:0] sof_marker;
    logic [7:0] eof_marker;

    // open frame tracking
    logic [8:0] frame_bytes;
    logic [7:0] quiet_ticks;
    logic [7:0] xor_acc;
    logic [7:0] head_byte;
    logic [7:0] tail_byte;
    logic       overflowed;
    pay_t       open_payload;
    pay_t       good_payload;

    frame_report_t frame_reports[$];
    logic [7:0]    frame_buf[$];

    int errors = 0;
    int frames_checked = 0;
    int words_sent = 0;
    int cfg_writes = 0;
    int cycles = 0;
    int burst_left = 0;
    bit sender_idles = 1'b0;
    int status_seen[6];
    int ready_cycle = 0;
    int ready_mode = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frames still pending", cycles,
                     frame_reports.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern, one of four modes picked at random
    always @(posedge clk)
    begin
        ready_cycle++;
        if (ready_cycle % 256 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: result_bus.ready <= 1'b1;
            1: result_bus.ready <= ($urandom_range(0, 3) != 0);
            2: result_bus.ready <= (ready_cycle % 7) < 3;
            default: result_bus.ready <= (ready_cycle % 40) >= 30;
        endcase
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 25)
            $display("mismatch in %s at frame %0d: got %0h, wanted %0h",
                     field, frames_checked, got, want);
    endtask

    function automatic void advance_frame_state(input opcode_t op, input logic [7:0] b);
        frame_report_t rep;
        status_t       st;
        if (op == OP_BYTE)
        begin
            quiet_ticks = 8'd0;
            if (frame_bytes < FRAME_DEPTH)
            begin
                if (frame_bytes == 0)
                    head_byte = b;
                if (frame_bytes >= PAY_FIRST && frame_bytes <= PAY_LAST)
                    open_payload[frame_bytes - PAY_FIRST] = b;
                tail_byte = b;
                xor_acc = xor_acc ^ b;
                frame_bytes++;
            end
            else
                overflowed = 1'b1;
        end
        else if (frame_bytes != 0)
        begin
            if (quiet_ticks != 8'hFF)
                quiet_ticks++;
            if (quiet_ticks >= gap_ticks)
            begin
                if (overflowed)
                    st = ST_OVERFLOW;
                else if (frame_bytes < MIN_FRAME)
                    st = ST_SHORT;
                else if (head_byte != sof_marker)
                    st = ST_BAD_START;
                else if (tail_byte != eof_marker)
                    st = ST_BAD_END;
                else if ((xor_acc ^ tail_byte) != 8'h00)
                    st = ST_BAD_SUM;
                else
                    st = ST_OK;
                if (st == ST_OK)
                    good_payload = open_payload;
                rep.status       = st;
                rep.frame_length = frame_bytes;
                rep.timestamp    = {good_payload[3], good_payload[2],
                                    good_payload[1], good_payload[0]};
                rep.phase_one    = {good_payload[5], good_payload[4]};
                rep.phase_two    = {good_payload[7], good_payload[6]};
                rep.phase_three  = {good_payload[9], good_payload[8]};
                rep.result_code  = good_payload[10];
                frame_reports.push_back(rep);
                frame_bytes  = '0;
                quiet_ticks  = '0;
                xor_acc      = '0;
                head_byte    = '0;
                tail_byte    = '0;
                overflowed   = 1'b0;
                open_payload = '0;
            end
        end
    endfunction

    task automatic check_report;
        frame_report_t want;
        if (frame_reports.size() == 0)
        begin
            report_mismatch("unexpected result word", {29'd0, result_bus.status}, 32'd0);
            return;
        end
        want = frame_reports.pop_front();
        frames_checked++;
        status_seen[want.status]++;
        if (result_bus.status !== want.status)
            report_mismatch("status", {29'd0, result_bus.status}, {29'd0, want.status});
        if (result_bus.frame_length !== want.frame_length)
            report_mismatch("frame_length", {23'd0, result_bus.frame_length},
                            {23'd0, want.frame_length});
        if (result_bus.timestamp !== want.timestamp)
            report_mismatch("timestamp", result_bus.timestamp, want.timestamp);
        if (result_bus.phase_one !== want.phase_one)
            report_mismatch("phase_one", {16'd0, result_bus.phase_one}, {16'd0, want.phase_one});
        if (result_bus.phase_two !== want.phase_two)
            report_mismatch("phase_two", {16'd0, result_bus.phase_two}, {16'd0, want.phase_two});
        if (result_bus.phase_three !== want.phase_three)
            report_mismatch("phase_three", {16'd0, result_bus.phase_three},
                            {16'd0, want.phase_three});
        if (result_bus.result_code !== want.result_code)
            report_mismatch("result_code", {24'd0, result_bus.result_code},
                            {24'd0, want.result_code});
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
                check_report();
            if (item_bus.valid && item_bus.ready)
                advance_frame_state(opcode_t'(item_bus.opcode), item_bus.rx_byte);
        end
    end

    task automatic send_word(input opcode_t op, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_idles ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                item_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = sender_idles ? $urandom_range(1, 12) : 1000;
        end
        burst_left--;
        item_bus.valid   <= 1'b1;
        item_bus.opcode  <= op;
        item_bus.rx_byte <= b;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_tick;
        send_word(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // enough ticks to close whatever is open, sometimes a few spare ones
    task automatic close_open_frame;
        int eff;
        eff = (gap_ticks == 0) ? 1 : int'(gap_ticks);
        repeat (eff) send_tick();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_tick();
    endtask

    task automatic drain_results;
        item_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (frame_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IDLE_TICKS:   gap_ticks  = value;
            CFG_START_MARKER: sof_marker = value;
            CFG_END_MARKER:   eof_marker = value;
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] idle, input logic [7:0] sof,
                                  input logic [7:0] eof);
        drain_results();
        write_reg(CFG_IDLE_TICKS, idle);
        write_reg(CFG_START_MARKER, sof);
        write_reg(CFG_END_MARKER, eof);
    endtask

    function automatic void seal_frame(input frame_flaw_t flaw);
        int         last;
        logic [7:0] acc;
        last = frame_buf.size() - 1;
        acc = 8'h00;
        frame_buf[0] = (flaw == BAD_HEAD) ? sof_marker ^ 8'($urandom_range(1, 255)) : sof_marker;
        if (last >= 1)
        begin
            for (int i = 0; i < last - 1; i++)
                acc = acc ^ frame_buf[i];
            frame_buf[last - 1] = (flaw == BAD_SUM) ? acc ^ 8'($urandom_range(1, 255)) : acc;
            frame_buf[last] = (flaw == BAD_TAIL) ?
                              eof_marker ^ 8'($urandom_range(1, 255)) : eof_marker;
        end
    endfunction

    task automatic fill_frame(input int len, input frame_flaw_t flaw);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
        seal_frame(flaw);
    endtask

    // bytes of frame_buf with a few ticks between them that stay under the timeout, then ticks to close the frame
    task automatic send_frame_buf;
        int eff;
        int cap;
        eff = (gap_ticks == 0) ? 1 : int'(gap_ticks);
        cap = (eff - 1 > 4) ? 4 : eff - 1;
        foreach (frame_buf[i])
        begin
            if (cap > 0 && $urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, cap)) send_tick();
            send_word(OP_BYTE, frame_buf[i]);
        end
        close_open_frame();
    endtask

    task automatic test_directed_frames;
        sender_idles = 1'b0;
        write_reg(CFG_IDLE_TICKS, 8'd0);
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'hFF);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_TICK, 8'h00);
        frame_buf = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00};
        seal_frame(CLEAN);
        foreach (frame_buf[i])
            send_word(OP_BYTE, frame_buf[i]);
        send_word(OP_TICK, 8'h7E);
        drain_results();
    endtask

    task automatic test_frame_limits;
        sender_idles = 1'b1;
        apply_settings(8'd2, 8'hAA, 8'h55);
        fill_frame(FRAME_DEPTH, CLEAN);
        send_frame_buf();
        fill_frame(FRAME_DEPTH + 3, CLEAN);
        send_frame_buf();
        fill_frame(20, BAD_SUM);
        send_frame_buf();
        drain_results();
    endtask

    task automatic test_slow_timeout;
        apply_settings(8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        fill_frame(18, CLEAN);
        send_frame_buf();
        drain_results();
    endtask

    task automatic test_random_traffic;
        int phase;
        int pick;
        int len;
        phase = 0;
        sender_idles = 1'b1;
        while (words_sent < ITEMS_TARGET)
        begin
            case (phase % 6)
                0: apply_settings(8'd1, 8'hAA, 8'h55);
                1: apply_settings(8'd2, 8'h00, 8'hFF);
                2: apply_settings(8'd3, 8'hFF, 8'h00);
                3: apply_settings(8'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                4: apply_settings(8'd5, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: apply_settings(8'($urandom_range(1, 8)), 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)));
            endcase
            for (int n = 0; n < 10 && words_sent < ITEMS_TARGET; n++)
            begin
                pick = $urandom_range(0, 99);
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 64)
                                                   : $urandom_range(16, 24);
                if (pick < 55)
                    fill_frame(len, CLEAN);
                else if (pick < 63)
                    fill_frame(len, BAD_HEAD);
                else if (pick < 71)
                    fill_frame(len, BAD_TAIL);
                else if (pick < 79)
                    fill_frame(len, BAD_SUM);
                else if (pick < 87)
                    fill_frame($urandom_range(1, 15), frame_flaw_t'($urandom_range(0, 3)));
                if (pick < 87)
                    send_frame_buf();
                else
                    repeat ($urandom_range(1, 20))
                        send_word(opcode_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) == 0)
                    drain_results();
            end
            close_open_frame();
            phase++;
        end
        drain_results();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_IDLE_TICKS;
        cfg_data            = 8'h00;
        item_bus.valid      = 1'b0;
        item_bus.opcode     = OP_BYTE;
        item_bus.rx_byte    = 8'h00;
        result_bus.ready    = 1'b0;
        gap_ticks           = IDLE_TICKS_RESET;
        sof_marker          = START_MARKER_RESET;
        eof_marker          = END_MARKER_RESET;
        frame_bytes         = '0;
        quiet_ticks         = '0;
        xor_acc             = '0;
        head_byte           = '0;
        tail_byte           = '0;
        overflowed          = 1'b0;
        open_payload        = '0;
        good_payload        = '0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_frame_limits();
        test_slow_timeout();
        test_random_traffic();
        drain_results();

        $display("sent %0d words, checked %0d frames, %0d register writes, %0d cycles",
                 words_sent, frames_checked, cfg_writes, cycles);
        $display("status counts: ok %0d ovf %0d short %0d start %0d end %0d sum %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
